// ===== design/anxb_pkg.sv =====
`default_nettype none
package anxb_pkg;

    localparam int BYTE_W  = 8;
    localparam int TYPE_W  = 5;
    localparam int STAMP_W = 32;
    localparam int TICKS_W = 17;
    localparam int PROD_W  = STAMP_W + TICKS_W;
    localparam int CNT_W   = $clog2(PROD_W + 1);
    localparam int PZ_W    = 2;
    localparam int ZCNT_W  = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [TICKS_W-1:0] TICKS_PER_SECOND = 17'd90000;
    localparam logic [TYPE_W-1:0]  HEADER_TYPE_MASK = 5'h1F;
    localparam logic [TYPE_W-1:0]  TYPE_SLICE       = 5'd1;
    localparam logic [TYPE_W-1:0]  TYPE_SLICE_IDR   = 5'd5;
    localparam logic [BYTE_W-1:0]  BYTE_ZERO        = 8'h00;
    localparam logic [BYTE_W-1:0]  BYTE_ONE         = 8'h01;
    localparam logic [BYTE_W-1:0]  FRAME_RATE_RESET = 8'd25;
    localparam logic [PZ_W-1:0]    PZ_MAX           = 2'd3;

    // register index as seen in paddr above the byte offset
    localparam logic REG_FRAME_RATE = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_NEXT  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_STAMP = 4'b1000
    } t_state;

    typedef struct packed {
        logic accept;
        logic consume;
        logic load;
        logic emit;
        logic last;
        logic close;
        logic finish;
        logic ts_start;
    } t_cmd;

    typedef struct packed {
        logic push_pend;
        logic close_pend;
        logic unit_open;
        logic held_valid;
        logic awaiting;
        logic out_free;
        logic ts_done;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/anxb_if.sv =====
`default_nettype none
interface anxb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        end_of_stream;

    modport source (output valid, data_byte, end_of_stream, input ready);
    modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

interface anxb_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        first_in_unit;
    logic        last_in_unit;
    logic [4:0]  unit_type;
    logic        idr_flag;
    logic [31:0] unit_timestamp;

    modport source (output valid, payload_byte, first_in_unit, last_in_unit, unit_type,
                    idr_flag, unit_timestamp, input ready);
    modport sink   (input valid, payload_byte, first_in_unit, last_in_unit, unit_type,
                    idr_flag, unit_timestamp, output ready);
endinterface
`default_nettype wire

// ===== design/anxb_ts.sv =====
`default_nettype none
module anxb_ts (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [anxb_pkg::STAMP_W-1:0]   i_slices,
    input  logic [anxb_pkg::BYTE_W-1:0]    i_rate,
    output logic                           o_done,
    output logic [anxb_pkg::STAMP_W-1:0]   o_quot
);
    import anxb_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_dvd;
    logic [BYTE_W-1:0] r_rem;
    logic [BYTE_W-1:0] r_div;

    logic [PROD_W-1:0] w_prod;
    logic [BYTE_W:0]   w_rem_sh;
    logic              w_ge;
    logic [BYTE_W:0]   w_rem_nx;

    assign w_prod   = PROD_W'(i_slices) * PROD_W'(TICKS_PER_SECOND);
    assign w_rem_sh = {r_rem, r_dvd[PROD_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(PROD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // restoring divide, one quotient bit per cycle shifted in from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= w_prod;
            r_rem <= '0;
            r_div <= (i_rate == '0) ? BYTE_W'(1) : i_rate;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[PROD_W-2:0], w_ge};
            r_rem <= w_rem_nx[BYTE_W-1:0];
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_quot = r_dvd[STAMP_W-1:0];

endmodule
`default_nettype wire

// ===== design/anxb_dp.sv =====
`default_nettype none
module anxb_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  anxb_pkg::t_cmd                 i_cmd,
    output anxb_pkg::t_stat                o_stat,
    input  logic [anxb_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                           i_end_of_stream,
    input  logic [anxb_pkg::BYTE_W-1:0]    i_frame_rate,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [anxb_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic                           o_first_in_unit,
    output logic                           o_last_in_unit,
    output logic [anxb_pkg::TYPE_W-1:0]    o_unit_type,
    output logic                           o_idr_flag,
    output logic [anxb_pkg::STAMP_W-1:0]   o_unit_timestamp
);
    import anxb_pkg::*;

    // per-beat work plan
    logic [BYTE_W-1:0]  r_byte;
    logic [ZCNT_W-1:0]  r_zeros_left;
    logic               r_push_b;
    logic               r_close;
    logic               r_open;
    logic               r_clear;

    // stream state
    logic               r_inside;
    logic [PZ_W-1:0]    r_pz;
    logic               r_held_valid;
    logic [BYTE_W-1:0]  r_held_value;
    logic               r_held_first;
    logic               r_awaiting;
    logic [TYPE_W-1:0]  r_kind;
    logic [STAMP_W-1:0] r_stamp;
    logic [STAMP_W-1:0] r_slices;

    // output register
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_first;
    logic               r_out_last;
    logic [TYPE_W-1:0]  r_out_type;
    logic [STAMP_W-1:0] r_out_stamp;

    logic               w_is_zero;
    logic               w_is_sc;
    logic               w_pz_full;
    logic [PZ_W-1:0]    w_pz_inc;
    logic [ZCNT_W-1:0]  n_zeros;
    logic [PZ_W-1:0]    n_pz;
    logic [BYTE_W-1:0]  w_push_val;
    logic [TYPE_W-1:0]  w_new_kind;
    logic               w_ts_done;
    logic [STAMP_W-1:0] w_ts_quot;

    assign w_is_zero = (i_data_byte == BYTE_ZERO);
    assign w_is_sc   = (i_data_byte == BYTE_ONE) && r_pz[PZ_W-1];
    assign w_pz_full = (r_pz == PZ_MAX);
    assign w_pz_inc  = w_pz_full ? r_pz : (r_pz + PZ_W'(1));

    always_comb begin
        if (w_is_zero) begin
            // a fourth zero releases one held zero; end of stream flushes the rest
            n_zeros = {{(ZCNT_W-1){1'b0}}, w_pz_full}
                    + (i_end_of_stream ? ZCNT_W'(w_pz_inc) : '0);
            n_pz    = i_end_of_stream ? '0 : w_pz_inc;
        end else if (w_is_sc) begin
            n_zeros = '0;
            n_pz    = '0;
        end else begin
            n_zeros = ZCNT_W'(r_pz);
            n_pz    = '0;
        end
    end

    assign w_push_val = (r_zeros_left != '0) ? BYTE_ZERO : r_byte;
    assign w_new_kind = w_push_val[TYPE_W-1:0] & HEADER_TYPE_MASK;

    anxb_ts u_ts (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.ts_start),
        .i_slices (r_slices),
        .i_rate   (i_frame_rate),
        .o_done   (w_ts_done),
        .o_quot   (w_ts_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.load) begin
            r_held_value <= w_push_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zeros_left <= '0;
            r_push_b     <= 1'b0;
            r_close      <= 1'b0;
            r_open       <= 1'b0;
            r_clear      <= 1'b0;
            r_inside     <= 1'b0;
            r_pz         <= '0;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_awaiting   <= 1'b0;
            r_kind       <= '0;
            r_stamp      <= '0;
            r_slices     <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_zeros_left <= n_zeros;
                r_push_b     <= !w_is_zero && !w_is_sc;
                r_close      <= w_is_sc || i_end_of_stream;
                r_open       <= w_is_sc;
                r_clear      <= i_end_of_stream;
                r_pz         <= n_pz;
            end
            if (i_cmd.consume || i_cmd.load) begin
                if (r_zeros_left != '0) begin
                    r_zeros_left <= r_zeros_left - ZCNT_W'(1);
                end else begin
                    r_push_b <= 1'b0;
                end
            end
            if (i_cmd.load) begin
                r_held_valid <= 1'b1;
                if (r_awaiting) begin
                    r_kind       <= w_new_kind;
                    r_stamp      <= w_ts_quot;
                    r_held_first <= 1'b1;
                    r_awaiting   <= 1'b0;
                    if (w_new_kind == TYPE_SLICE || w_new_kind == TYPE_SLICE_IDR) begin
                        r_slices <= r_slices + STAMP_W'(1);
                    end
                end else begin
                    r_held_first <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_held_valid <= 1'b0;
            end
            if (i_cmd.close) begin
                r_close      <= 1'b0;
                r_held_valid <= 1'b0;
                r_held_first <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_open  <= 1'b0;
                r_clear <= 1'b0;
                if (r_clear) begin
                    r_inside     <= 1'b0;
                    r_awaiting   <= 1'b0;
                    r_held_valid <= 1'b0;
                    r_held_first <= 1'b0;
                    r_kind       <= '0;
                    r_stamp      <= '0;
                    r_slices     <= '0;
                end else if (r_open) begin
                    r_inside   <= 1'b1;
                    r_awaiting <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte  <= r_held_value;
            r_out_first <= r_held_first;
            r_out_last  <= i_cmd.last;
            r_out_type  <= r_kind;
            r_out_stamp <= r_stamp;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_byte   = r_out_byte;
    assign o_first_in_unit  = r_out_first;
    assign o_last_in_unit   = r_out_last;
    assign o_unit_type      = r_out_type;
    assign o_idr_flag       = (r_out_type == TYPE_SLICE_IDR);
    assign o_unit_timestamp = r_out_stamp;

    assign o_stat.push_pend  = (r_zeros_left != '0) || r_push_b;
    assign o_stat.close_pend = r_close;
    assign o_stat.unit_open  = r_inside;
    assign o_stat.held_valid = r_held_valid;
    assign o_stat.awaiting   = r_awaiting;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.ts_done    = w_ts_done;

endmodule
`default_nettype wire

// ===== design/anxb_ctrl.sv =====
`default_nettype none
module anxb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  anxb_pkg::t_stat  i_stat,
    output anxb_pkg::t_cmd   o_cmd
);
    import anxb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (i_stat.push_pend) begin
                    if (!i_stat.unit_open) begin
                        // no unit open yet: byte is dropped
                        o_cmd.consume = 1'b1;
                    end else if (i_stat.held_valid) begin
                        n_state = ST_EMIT;
                    end else if (i_stat.awaiting) begin
                        o_cmd.ts_start = 1'b1;
                        n_state        = ST_STAMP;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end else if (i_stat.close_pend) begin
                    if (i_stat.held_valid) begin
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.close = 1'b1;
                    end
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    // held byte is last only when a close, not a push, flushes it
                    o_cmd.last = !i_stat.push_pend;
                    n_state    = ST_NEXT;
                end
            end
            ST_STAMP: begin
                if (i_stat.ts_done) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_NEXT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/annexb_nal_unit_splitter.sv =====
`default_nettype none
// Annex B splitter: takes an H.264 byte stream one byte per beat and delivers the payload
// bytes of each NAL unit with start codes (00 00 01 or 00 00 00 01) removed, one byte
// behind the input so the final byte of a unit can carry last_in_unit. Every output beat
// carries the unit type, an IDR flag and a 90 kHz timestamp of slices-so-far * 90000 /
// frame_rate (frame_rate 0 acts as 1); bytes before the first start code and empty units
// produce nothing, and end_of_stream flushes the open unit and clears the slice count.
// An input byte is taken only in the idle state, and the block releases, drops or holds
// the pending bytes and closes a finished unit before it takes the next byte; the
// header byte of a unit also waits for the timestamp divider, which works the
// 49-bit product down one quotient bit per cycle. A taken output beat waits in an output
// register, so the output side can stall while the next input byte is already being
// worked on; a stalled output holds the block at the next beat it has to release.
module annexb_nal_unit_splitter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    anxb_in_if.sink                        i_in,
    anxb_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [anxb_pkg::PADDR_W-1:0]   paddr,
    input  logic [anxb_pkg::PDATA_W-1:0]   pwdata,
    output logic [anxb_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import anxb_pkg::*;

    logic [BYTE_W-1:0] r_frame_rate;
    logic              w_sel_rate;
    t_cmd              w_cmd;
    t_stat             w_stat;

    assign w_sel_rate = (paddr[PADDR_W-1] == REG_FRAME_RATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate <= FRAME_RATE_RESET;
        end else if (psel && penable && pwrite && w_sel_rate) begin
            r_frame_rate <= pwdata[BYTE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = w_sel_rate ? PDATA_W'(r_frame_rate) : '0;

    anxb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    anxb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_data_byte      (i_in.data_byte),
        .i_end_of_stream  (i_in.end_of_stream),
        .i_frame_rate     (r_frame_rate),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_payload_byte   (o_out.payload_byte),
        .o_first_in_unit  (o_out.first_in_unit),
        .o_last_in_unit   (o_out.last_in_unit),
        .o_unit_type      (o_out.unit_type),
        .o_idr_flag       (o_out.idr_flag),
        .o_unit_timestamp (o_out.unit_timestamp)
    );

endmodule
`default_nettype wire
